/* rtl/core/lgs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types, constants and helper functions of the life generation
// stencil core: register indexes, hash constants, window rule and mixer.
// ----------------------------------------------------------------------------
package lgs_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_SEED   = 2'd2;

   localparam int SIZE_W = 12;
   localparam int HASH_W = 32;
   localparam int POS_OUT_W = 11;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd2048;
   localparam logic [HASH_W-1:0] SEED_RESET = 32'h00C0_FFEE;

   // hash multipliers and the substitute for a zero hash
   localparam logic [HASH_W-1:0] HASH_K_ROW    = 32'd2654435761;
   localparam logic [HASH_W-1:0] HASH_K_COL    = 32'd2246822519;
   localparam logic [HASH_W-1:0] HASH_K_GEN    = 32'd3266489917;
   localparam logic [HASH_W-1:0] HASH_ZERO_SUB = 32'h9E37_79B9;
   localparam int XS_SHIFT_A = 13;
   localparam int XS_SHIFT_B = 17;
   localparam int XS_SHIFT_C = 5;

   // result queue between the stencil and the hash pipe
   localparam int RQ_DEPTH = 8;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = RQ_PTR_W + 1;

   // 3x3 window: three columns of 3 bits, oldest column in bits 0-2
   localparam int WIN_W = 9;
   localparam int COL3_W = 3;

   // per-word control handed from the sequencer to the stencil stage
   typedef struct packed {
      logic is_cell;     // cell word (line store written), else drain word
      logic row_first;   // first row of the frame
      logic col_first;   // first column of the row
      logic alive;       // alive bit of the incoming cell
      logic col_last;    // last column of the row
      logic emit_a;      // emit the cell one column back
      logic emit_b;      // emit the current column at the row end
      logic frame_last;  // second result closes the generation
   } stencil_ctl_type;

   // B3/S23 rule on a window, centre in bit 4
   function automatic logic next_live(input logic [WIN_W-1:0] win);
      logic [3:0] count;
      count = '0;
      for (int i = 0; i < WIN_W; i++) begin
         if (i != 4) begin
            count = count + 4'(win[i]);
         end
      end
      if (win[4]) begin
         return (count == 4'd2) || (count == 4'd3);
      end
      return count == 4'd3;
   endfunction

   // xorshift32 finish with zero replaced
   function automatic logic [HASH_W-1:0] xorshift_mix(input logic [HASH_W-1:0] x_in);
      logic [HASH_W-1:0] x;
      x = x_in;
      x = x ^ (x << XS_SHIFT_A);
      x = x ^ (x >> XS_SHIFT_B);
      x = x ^ (x << XS_SHIFT_C);
      if (x == '0) begin
         x = HASH_ZERO_SUB;
      end
      return x;
   endfunction

endpackage

/* rtl/core/lgs_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_sequencer
// Tracks the raster position, the drain phase and the generation term,
// accepts request words against queue credit and issues line store reads.
// ----------------------------------------------------------------------------
module lgs_sequencer
   import lgs_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic                  req_cell_alive,
   input  logic [SIZE_W-1:0]     grid_width,
   input  logic [SIZE_W-1:0]     grid_height,
   input  logic [RQ_CNT_W-1:0]   rq_count,
   output logic                  rd_en,
   output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0]  rd_idx,
   output logic                  s1_valid,
   output stencil_ctl_type       s1_ctl,
   output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0]  s1_col,
   output logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] s1_row,
   output logic [HASH_W-1:0]     s1_gen_term
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW = CW + 1;
   localparam int HW = RW + 1;

   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic              draining_ff, draining_in;
   logic [HASH_W-1:0] gen_term_ff, gen_term_in;
   logic              s1_valid_ff;
   stencil_ctl_type   s1_ctl_ff, s1_ctl_in;
   logic [CW-1:0]     s1_col_ff;
   logic [RW-1:0]     s1_row_ff, s1_row_in;
   logic [HASH_W-1:0] s1_gen_ff;

   logic [WW-1:0]       eff_w;
   logic [HW-1:0]       eff_h;
   logic                col_last, row_last, accept, take;
   logic [RQ_CNT_W:0]   need_slots;

   // clamp the configured sizes to 1..max
   always_comb begin
      if (grid_width == '0) begin
         eff_w = WW'(1);
      end else if (32'(grid_width) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(grid_width);
      end
      if (grid_height == '0) begin
         eff_h = HW'(1);
      end else if (32'(grid_height) > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(grid_height);
      end
   end

   // hold off while the queue may lack room for two results of this word
   // and two of the word in the stencil stage
   assign need_slots = {1'b0, rq_count} +
                       (s1_valid_ff ? (RQ_CNT_W+1)'(2) : (RQ_CNT_W+1)'(0));
   assign req_stall  = need_slots > (RQ_CNT_W+1)'(RQ_DEPTH - 2);
   assign accept     = req_valid && !req_stall;
   // a word of the wrong kind is dropped
   assign take       = accept && (draining_ff ? req_type : !req_type);

   assign col_last = (WW'(col_ff) + WW'(1)) >= eff_w;
   assign row_last = (HW'(row_ff) + HW'(1)) >= eff_h;

   // control for the stencil stage
   always_comb begin
      s1_ctl_in.is_cell    = !draining_ff;
      s1_ctl_in.row_first  = row_ff == '0;
      s1_ctl_in.col_first  = col_ff == '0;
      s1_ctl_in.alive      = req_cell_alive;
      s1_ctl_in.col_last   = col_last;
      s1_ctl_in.emit_a     = (col_ff != '0) && (draining_ff || (row_ff != '0));
      s1_ctl_in.emit_b     = col_last && (draining_ff || (row_ff != '0));
      s1_ctl_in.frame_last = draining_ff && col_last;
      s1_row_in            = draining_ff ? row_ff : (row_ff - RW'(1));
   end

   // advance the raster position
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      draining_in = draining_ff;
      gen_term_in = gen_term_ff;
      if (take) begin
         if (col_last) begin
            col_in = '0;
            if (draining_ff) begin
               draining_in = 1'b0;
               row_in      = '0;
               gen_term_in = gen_term_ff + HASH_K_GEN;
            end else if (row_last) begin
               draining_in = 1'b1;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         draining_ff <= 1'b0;
         gen_term_ff <= HASH_K_GEN;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         draining_ff <= draining_in;
         gen_term_ff <= gen_term_in;
         s1_valid_ff <= take;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_ctl_ff <= s1_ctl_in;
         s1_col_ff <= col_ff;
         s1_row_ff <= s1_row_in;
         s1_gen_ff <= gen_term_ff;
      end
   end

   assign rd_en       = take;
   assign rd_idx      = col_ff;
   assign s1_valid    = s1_valid_ff;
   assign s1_ctl      = s1_ctl_ff;
   assign s1_col      = s1_col_ff;
   assign s1_row      = s1_row_ff;
   assign s1_gen_term = s1_gen_ff;

endmodule

/* rtl/core/lgs_stencil.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_stencil
// Line store memory with read-modify-write, the 3x3 neighbor window and the
// B3/S23 decision for the one or two cells released by each word.
// ----------------------------------------------------------------------------
module lgs_stencil
   import lgs_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] rd_idx,
   input  logic                  s1_valid,
   input  stencil_ctl_type       s1_ctl,
   input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] s1_col,
   output logic                  live_a,
   output logic                  live_b
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // bit 0: row above the newest, bit 1: two rows above
   logic [1:0]       line_mem [MAX_WIDTH];
   logic [1:0]       rd_data_ff;
   logic             fwd_ff;
   logic [1:0]       fwd_data_ff;
   logic [WIN_W-1:0] win_ff, win_in;

   logic             wr_en;
   logic [1:0]       old, wdata;
   logic [COL3_W-1:0] col3;
   logic [WIN_W-1:0] base, win_a, win_b;

   // forward a write that lands on the edge of a read of the same entry
   assign old   = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign wr_en = s1_valid && s1_ctl.is_cell;

   always_comb begin
      if (!s1_ctl.is_cell) begin
         col3  = {1'b0, old[0], old[1]};
         wdata = old;
      end else if (s1_ctl.row_first) begin
         col3  = {s1_ctl.alive, 2'b00};
         wdata = {1'b0, s1_ctl.alive};
      end else begin
         col3  = {s1_ctl.alive, old[0], old[1]};
         wdata = {old[0], s1_ctl.alive};
      end
   end

   // shift the new column in, then once more at the row end
   assign base   = s1_ctl.col_first ? '0 : win_ff;
   assign win_a  = {col3, base[WIN_W-1:COL3_W]};
   assign win_b  = {{COL3_W{1'b0}}, win_a[WIN_W-1:COL3_W]};
   assign win_in = s1_valid ? (s1_ctl.col_last ? win_b : win_a) : win_ff;

   assign live_a = next_live(win_a);
   assign live_b = next_live(win_b);

   // line store: one read port, one write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_idx];
      end
      if (wr_en) begin
         line_mem[s1_col] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
         win_ff <= '0;
      end else begin
         fwd_ff <= rd_en && wr_en && (rd_idx == s1_col);
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wdata;
   end

endmodule

/* rtl/core/lgs_result_path.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_result_path
// Result queue taking up to two cells a cycle, followed by a two-stage hash
// pipe (constant products, then xor and xorshift into the output register).
// ----------------------------------------------------------------------------
module lgs_result_path
   import lgs_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  s1_valid,
   input  stencil_ctl_type       s1_ctl,
   input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0]  s1_col,
   input  logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] s1_row,
   input  logic [HASH_W-1:0]     s1_gen_term,
   input  logic                  live_a,
   input  logic                  live_b,
   input  logic [HASH_W-1:0]     hash_seed,
   output logic [RQ_CNT_W-1:0]   rq_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [HASH_W-1:0]     rsp_cell_value,
   output logic                  rsp_next_live,
   output logic [POS_OUT_W-1:0]  rsp_out_row,
   output logic [POS_OUT_W-1:0]  rsp_out_col,
   output logic                  rsp_frame_last
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // queue storage
   logic              q_live [RQ_DEPTH];
   logic              q_last [RQ_DEPTH];
   logic [RW-1:0]     q_row  [RQ_DEPTH];
   logic [CW-1:0]     q_col  [RQ_DEPTH];
   logic [HASH_W-1:0] q_gen  [RQ_DEPTH];

   logic [RQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0] count_ff, count_in;

   logic                push_a, push_b, push_any, push_two, pop;
   logic [RQ_PTR_W-1:0] wr_ptr_nx;
   logic                slot0_live, slot0_last;
   logic [CW-1:0]       slot0_col;

   // hash pipe
   logic                 h1_valid_ff;
   logic [HASH_W-1:0]    h1_prod_row_ff, h1_prod_col_ff, h1_gen_ff;
   logic                 h1_live_ff, h1_last_ff;
   logic [POS_OUT_W-1:0] h1_row_ff, h1_col_ff;
   logic                 rsp_valid_ff;
   logic [HASH_W-1:0]    rsp_value_ff;
   logic                 rsp_live_ff, rsp_last_ff;
   logic [POS_OUT_W-1:0] rsp_row_ff, rsp_col_ff;

   logic                 out_ready, h1_ready;
   logic [HASH_W-1:0]    mix_in, mix_out;

   // the earlier cell goes first when both are released
   assign push_a    = s1_valid && s1_ctl.emit_a;
   assign push_b    = s1_valid && s1_ctl.emit_b;
   assign push_any  = push_a || push_b;
   assign push_two  = push_a && push_b;
   assign wr_ptr_nx = wr_ptr_ff + RQ_PTR_W'(1);
   assign slot0_live = push_a ? live_a : live_b;
   assign slot0_last = push_a ? 1'b0 : s1_ctl.frame_last;
   assign slot0_col  = push_a ? (s1_col - CW'(1)) : s1_col;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign h1_ready  = !h1_valid_ff || out_ready;
   assign pop       = (count_ff != '0) && h1_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_two) begin
         wr_ptr_in = wr_ptr_ff + RQ_PTR_W'(2);
      end else if (push_any) begin
         wr_ptr_in = wr_ptr_nx;
      end
      rd_ptr_in = pop ? rd_ptr_ff + RQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RQ_CNT_W'(push_a) + RQ_CNT_W'(push_b) - RQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write one or two queue entries
   always_ff @(posedge clock) begin
      if (push_any) begin
         q_live[wr_ptr_ff] <= slot0_live;
         q_last[wr_ptr_ff] <= slot0_last;
         q_row[wr_ptr_ff]  <= s1_row;
         q_col[wr_ptr_ff]  <= slot0_col;
         q_gen[wr_ptr_ff]  <= s1_gen_term;
      end
      if (push_two) begin
         q_live[wr_ptr_nx] <= live_b;
         q_last[wr_ptr_nx] <= s1_ctl.frame_last;
         q_row[wr_ptr_nx]  <= s1_row;
         q_col[wr_ptr_nx]  <= s1_col;
         q_gen[wr_ptr_nx]  <= s1_gen_term;
      end
   end

   // fold the position terms, finish the hash
   assign mix_in  = hash_seed ^ h1_prod_row_ff ^ h1_prod_col_ff ^ h1_gen_ff;
   assign mix_out = xorshift_mix(mix_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (h1_ready) begin
            h1_valid_ff <= pop;
         end
         if (out_ready) begin
            rsp_valid_ff <= h1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         h1_prod_row_ff <= HASH_W'(HASH_W'(q_row[rd_ptr_ff]) * HASH_K_ROW);
         h1_prod_col_ff <= HASH_W'(HASH_W'(q_col[rd_ptr_ff]) * HASH_K_COL);
         h1_gen_ff      <= q_gen[rd_ptr_ff];
         h1_live_ff     <= q_live[rd_ptr_ff];
         h1_last_ff     <= q_last[rd_ptr_ff];
         h1_row_ff      <= POS_OUT_W'(q_row[rd_ptr_ff]);
         h1_col_ff      <= POS_OUT_W'(q_col[rd_ptr_ff]);
      end
      if (h1_valid_ff && out_ready) begin
         rsp_value_ff <= h1_live_ff ? mix_out : '0;
         rsp_live_ff  <= h1_live_ff;
         rsp_last_ff  <= h1_last_ff;
         rsp_row_ff   <= h1_row_ff;
         rsp_col_ff   <= h1_col_ff;
      end
   end

   assign rq_count       = count_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_next_live  = rsp_live_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

/* rtl/core/life_generation_stencil_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_stencil_core
// One Conway B3/S23 generation over a raster stream of alive bits, with a
// hashed value for every cell that is live in the next generation.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_*) carry one current-generation cell each, in raster
//   order, W*H of them, followed by W drain words (req_type = 1). A word of
//   the wrong kind is dropped. Result words (rsp_*) carry row r-1 while row
//   r streams in, then the last row during the drain; frame_last marks the
//   final cell, after which the generation count advances.
//   Throughput is one request word per cycle while req_stall is low, set by
//   the single line store read-modify-write per word. A word releases at
//   most two cells, each passing the stencil stage register, the result
//   queue, the hash register and the output register. An 8-entry result
//   queue precedes the hash pipe; req_stall rises when it may lack room,
//   so a stalled receiver holds its word stable and backs up into req_stall.
//   Reset (synchronous) restores the default size 2048 x 2048, the default
//   seed, the start of frame and generation zero; the line store needs no
//   clearing. Write csr_* only while no word is in flight.
// ----------------------------------------------------------------------------
module life_generation_stencil_core
   import lgs_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  logic                   req_cell_alive,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [HASH_W-1:0]      rsp_cell_value,
   output logic                   rsp_next_live,
   output logic [POS_OUT_W-1:0]   rsp_out_row,
   output logic [POS_OUT_W-1:0]   rsp_out_col,
   output logic                   rsp_frame_last,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [SIZE_W-1:0] grid_width_ff, grid_width_in;
   logic [SIZE_W-1:0] grid_height_ff, grid_height_in;
   logic [HASH_W-1:0] hash_seed_ff, hash_seed_in;

   logic [RQ_CNT_W-1:0] rq_count;
   logic                rd_en;
   logic [CW-1:0]       rd_idx;
   logic                s1_valid;
   stencil_ctl_type     s1_ctl;
   logic [CW-1:0]       s1_col;
   logic [RW-1:0]       s1_row;
   logic [HASH_W-1:0]   s1_gen_term;
   logic                live_a, live_b;

   // decode register writes
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      hash_seed_in   = hash_seed_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_wdata[SIZE_W-1:0];
            CSR_GRID_HEIGHT: grid_height_in = csr_wdata[SIZE_W-1:0];
            CSR_HASH_SEED:   hash_seed_in   = csr_wdata[HASH_W-1:0];
            default: begin
               grid_width_in = grid_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIZE_RESET;
         grid_height_ff <= SIZE_RESET;
         hash_seed_ff   <= SEED_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         hash_seed_ff   <= hash_seed_in;
      end
   end

   lgs_sequencer #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_cell_alive (req_cell_alive),
      .grid_width     (grid_width_ff),
      .grid_height    (grid_height_ff),
      .rq_count       (rq_count),
      .rd_en          (rd_en),
      .rd_idx         (rd_idx),
      .s1_valid       (s1_valid),
      .s1_ctl         (s1_ctl),
      .s1_col         (s1_col),
      .s1_row         (s1_row),
      .s1_gen_term    (s1_gen_term)
   );

   lgs_stencil #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_stencil (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx),
      .s1_valid (s1_valid),
      .s1_ctl   (s1_ctl),
      .s1_col   (s1_col),
      .live_a   (live_a),
      .live_b   (live_b)
   );

   lgs_result_path #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_result_path (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid),
      .s1_ctl         (s1_ctl),
      .s1_col         (s1_col),
      .s1_row         (s1_row),
      .s1_gen_term    (s1_gen_term),
      .live_a         (live_a),
      .live_b         (live_b),
      .hash_seed      (hash_seed_ff),
      .rq_count       (rq_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_next_live  (rsp_next_live),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

/* verif/life_generation_stencil_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_stencil_core_tb
// Self-checking bench for the streaming B3/S23 generation core. Cell and
// drain words go in through the request channel under random idling and
// back-pressure. A local model of the line store, the 3x3 window and the
// frame position predicts every result word, and a checker compares each
// accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module life_generation_stencil_core_tb
   import lgs_pkg::*;
;

   localparam int MAX_CELLS     = 2048;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_REPORTS   = 50;

   localparam logic WORD_CELL  = 1'b0;
   localparam logic WORD_DRAIN = 1'b1;

   localparam logic [31:0] ROW_MULT      = 32'd2654435761;
   localparam logic [31:0] COL_MULT      = 32'd2246822519;
   localparam logic [31:0] GEN_MULT      = 32'd3266489917;
   localparam logic [31:0] ZERO_HASH_SUB = 32'h9E37_79B9;

   typedef struct packed {
      logic [31:0] value;
      logic        live;
      logic [10:0] row;
      logic [10:0] col;
      logic        last;
   } cell_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_type = 1'b0;
   logic                   req_cell_alive = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [HASH_W-1:0]      rsp_cell_value;
   logic                   rsp_next_live;
   logic [POS_OUT_W-1:0]   rsp_out_row;
   logic [POS_OUT_W-1:0]   rsp_out_col;
   logic                   rsp_frame_last;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_GRID_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // model of the block: registers, line store, window and frame position
   logic [11:0]  width_reg;
   logic [11:0]  height_reg;
   logic [31:0]  seed_reg;
   logic [1:0]   row_history [0:MAX_CELLS-1];
   logic [8:0]   window_bits;
   int unsigned  cur_row;
   int unsigned  cur_col;
   bit           in_drain;
   int unsigned  drain_pos;
   logic [31:0]  gen_index;

   cell_word_type pending_cells [$];
   int unsigned  words_consumed = 0;
   int unsigned  fail_count = 0;
   int unsigned  tx_idle_pct = 0;
   int unsigned  rx_idle_pct = 0;
   int unsigned  hold_requests = 0;
   int unsigned  hold_served = 0;
   int unsigned  hold_left = 0;

   life_generation_stencil_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_cell_alive (req_cell_alive),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_next_live  (rsp_next_live),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // model
   // ---------------------------------------------------------------------

   // clamp a size register to the range the block supports
   function automatic int unsigned eff_size(input logic [11:0] v);
      if (v == 12'd0) begin
         return 1;
      end
      if (v > MAX_CELLS) begin
         return MAX_CELLS;
      end
      return 32'(v);
   endfunction

   // birth on three neighbours, survival on two or three
   function automatic logic b3s23_next(input logic [8:0] win);
      int n;
      n = 0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            n += int'(win[i]);
         end
      end
      return win[4] ? (n == 2 || n == 3) : (n == 3);
   endfunction

   function automatic logic [31:0] live_value(input logic [31:0] row, input logic [31:0] col,
                                              input logic [31:0] gen);
      logic [31:0] x;
      x = seed_reg ^ (row * ROW_MULT) ^ (col * COL_MULT) ^ (gen * GEN_MULT);
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return (x == 32'd0) ? ZERO_HASH_SUB : x;
   endfunction

   // predict the window centre as one result word
   task automatic push_cell(input int unsigned row, input int unsigned col, input logic last);
      cell_word_type e;
      e.live  = b3s23_next(window_bits);
      e.value = e.live ? live_value(row, col, gen_index + 32'd1) : 32'd0;
      e.row   = 11'(row);
      e.col   = 11'(col);
      e.last  = last;
      pending_cells.push_back(e);
   endtask

   task automatic shift_window(input logic [2:0] col3, input int unsigned c);
      if (c == 0) begin
         window_bits = '0;
      end
      window_bits = {col3, window_bits[8:3]};
   endtask

   // advance the model by one accepted word; drop words of the wrong kind
   task automatic advance_life_model(input logic kind, input logic alive, output bit consumed);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      logic [1:0]  old;
      logic [2:0]  col3;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      consumed = 1'b0;
      if (!in_drain) begin
         if (kind != WORD_CELL) begin
            return;
         end
         consumed = 1'b1;
         c = cur_col;
         old = row_history[c];
         if (cur_row == 0) begin
            col3 = {alive, 2'b00};
            row_history[c] = {1'b0, alive};
         end else begin
            col3 = {alive, old[0], old[1]};
            row_history[c] = {old[0], alive};
         end
         shift_window(col3, c);
         if (cur_row >= 1 && c >= 1) begin
            push_cell(cur_row - 1, c - 1, 1'b0);
         end
         if (c + 1 >= w) begin
            window_bits = window_bits >> 3;
            if (cur_row >= 1) begin
               push_cell(cur_row - 1, c, 1'b0);
            end
            cur_col = 0;
            if (cur_row + 1 >= h) begin
               in_drain = 1'b1;
               drain_pos = 0;
            end else begin
               cur_row++;
            end
         end else begin
            cur_col = c + 1;
         end
      end else begin
         if (kind != WORD_DRAIN) begin
            return;
         end
         consumed = 1'b1;
         c = drain_pos;
         old = row_history[c];
         shift_window({1'b0, old[0], old[1]}, c);
         if (c >= 1) begin
            push_cell(cur_row, c - 1, 1'b0);
         end
         if (c + 1 >= w) begin
            window_bits = window_bits >> 3;
            push_cell(cur_row, c, 1'b1);
            in_drain = 1'b0;
            drain_pos = 0;
            cur_row = 0;
            cur_col = 0;
            gen_index++;
         end else begin
            drain_pos = c + 1;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endtask

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      cell_word_type got;
      cell_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_cell_value, rsp_next_live, rsp_out_row, rsp_out_col, rsp_frame_last};
         if (pending_cells.size() == 0) begin
            report_mismatch($sformatf("unexpected result word row %0d col %0d",
                                      got.row, got.col));
         end else begin
            want = pending_cells.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf(
                  "got %h/%b/%0d/%0d/%b, expected %h/%b/%0d/%0d/%b (value/live/row/col/last)",
                  got.value, got.live, got.row, got.col, got.last,
                  want.value, want.live, want.row, want.col, want.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stalls, plus long holds on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_served <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall <= 1'b1;
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   task automatic set_idle(input int unsigned tx_pct, input int unsigned rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct <= rx_pct;
   endtask

   // offer one word, hold it until accepted, then advance the model
   task automatic send_word(input logic kind, input logic alive);
      bit consumed;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_cell_alive <= alive;
      do @(posedge clock); while (req_stall);
      advance_life_model(kind, alive, consumed);
      if (consumed) begin
         words_consumed++;
      end
   endtask

   // stop offering and wait until every predicted word is out
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_cells.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic drive_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_GRID_WIDTH:  width_reg = data[11:0];
         CSR_GRID_HEIGHT: height_reg = data[11:0];
         CSR_HASH_SEED:   seed_reg = data;
         default: ;
      endcase
   endtask

   // write the selected registers (bit 0 width, 1 height, 2 seed) once idle
   task automatic write_regs(input logic [2:0] mask, input logic [11:0] w,
                             input logic [11:0] h, input logic [31:0] seed);
      settle_block();
      if (mask[0]) begin
         drive_csr(CSR_GRID_WIDTH, {20'd0, w});
      end
      if (mask[1]) begin
         drive_csr(CSR_GRID_HEIGHT, {20'd0, h});
      end
      if (mask[2]) begin
         drive_csr(CSR_HASH_SEED, seed);
      end
      csr_write_en <= 1'b0;
   endtask

   // finish the current frame with random cells; optionally shrink it midway
   task automatic run_frame(input int unsigned density, input int unsigned noise_pct,
                            input bit resize);
      int unsigned cells;
      int unsigned cut_at;
      int unsigned sent;
      cells = eff_size(width_reg) * eff_size(height_reg);
      cut_at = 0;
      sent = 0;
      if (resize && cells > 1) begin
         cut_at = $urandom_range(cells - 1, 1);
      end
      while (!in_drain) begin
         if (cut_at != 0 && sent == cut_at) begin
            // shrink only: a wider row would read unwritten history
            write_regs(3'b011, 12'($urandom_range(eff_size(width_reg), 1)),
                       12'($urandom_range(eff_size(height_reg), 1)), seed_reg);
         end
         if ($urandom_range(99) < noise_pct) begin
            send_word(WORD_DRAIN, 1'($urandom_range(1)));
         end
         send_word(WORD_CELL, $urandom_range(99) < density);
         sent++;
      end
      while (in_drain) begin
         if ($urandom_range(99) < noise_pct) begin
            send_word(WORD_CELL, 1'($urandom_range(1)));
         end
         send_word(WORD_DRAIN, 1'($urandom_range(1)));
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // vertical blinker turns horizontal; stray words of the wrong kind dropped
   task automatic test_blinker_wrong_kind();
      write_regs(3'b011, 12'd3, 12'd3, 32'd0);
      send_word(WORD_DRAIN, 1'b1);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            send_word(WORD_CELL, c == 1);
         end
      end
      send_word(WORD_CELL, 1'b1);
      for (int d = 0; d < 3; d++) begin
         send_word(WORD_DRAIN, 1'b0);
      end
   endtask

   // zero sizes count as one: a single cell, emitted by the only drain
   task automatic test_unit_grid();
      write_regs(3'b111, 12'd0, 12'd0, 32'hFFFF_FFFF);
      send_word(WORD_CELL, 1'b1);
      send_word(WORD_DRAIN, 1'b1);
   endtask

   // seed chosen so cell (0,0) hashes to zero and gets the substitute
   task automatic test_zero_hash();
      write_regs(3'b111, 12'd2, 12'd2, (gen_index + 32'd1) * GEN_MULT);
      for (int i = 0; i < 4; i++) begin
         send_word(WORD_CELL, 1'b1);
      end
      send_word(WORD_DRAIN, 1'b0);
      send_word(WORD_DRAIN, 1'b0);
   endtask

   // shrink width and height while inside the third row
   task automatic test_mid_frame_resize();
      write_regs(3'b111, 12'd4, 12'd4, 32'h1234_5678);
      for (int i = 0; i < 10; i++) begin
         send_word(WORD_CELL, i[0] ^ i[2]);
      end
      write_regs(3'b011, 12'd1, 12'd1, 32'd0);
      run_frame(50, 0, 1'b0);
   endtask

   // receiver holds off long while the sender keeps offering
   task automatic test_backpressure();
      write_regs(3'b111, 12'd12, 12'd12, $urandom());
      hold_requests <= hold_requests + 1;
      run_frame(40, 0, 1'b0);
   endtask

   // oversize width, then oversize height, each cut short by a shrink
   task automatic test_size_extremes();
      write_regs(3'b111, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
      for (int i = 0; i < 30; i++) begin
         send_word(WORD_CELL, 1'($urandom_range(1)));
      end
      write_regs(3'b011, 12'd30, 12'd3, 32'd0);
      run_frame(50, 0, 1'b0);
      write_regs(3'b111, 12'd1, 12'd4095, 32'd0);
      for (int i = 0; i < 30; i++) begin
         send_word(WORD_CELL, 1'($urandom_range(1)));
      end
      write_regs(3'b011, 12'd1, 12'd1, 32'd0);
      run_frame(50, 0, 1'b0);
   endtask

   task automatic test_random_frames(input int unsigned budget);
      int unsigned start;
      int unsigned w;
      int unsigned h;
      start = words_consumed;
      while (words_consumed - start < budget) begin
         if ($urandom_range(3) != 0) begin
            if ($urandom_range(19) == 0) begin
               w = $urandom_range(160, 41);
               h = $urandom_range(2, 1);
            end else begin
               w = $urandom_range(10, 1);
               h = $urandom_range(10, 1);
            end
            write_regs(3'b111, 12'(w), 12'(h), $urandom());
         end
         run_frame($urandom_range(100), $urandom_range(1) ? $urandom_range(5) : 0,
                   $urandom_range(7) == 0);
      end
   endtask

   initial begin
      width_reg = 12'd2048;
      height_reg = 12'd2048;
      seed_reg = 32'h00C0_FFEE;
      for (int i = 0; i < MAX_CELLS; i++) begin
         row_history[i] = 2'b00;
      end
      window_bits = '0;
      cur_row = 0;
      cur_col = 0;
      in_drain = 1'b0;
      drain_pos = 0;
      gen_index = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_idle(19, 75);
      test_blinker_wrong_kind();
      test_unit_grid();
      test_zero_hash();
      test_mid_frame_resize();
      test_random_frames(120);

      set_idle(75, 19);
      test_random_frames(120);

      set_idle(0, 0);
      test_backpressure();
      test_size_extremes();
      test_random_frames(100);

      settle_block();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hard stop for a hung handshake
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* life_generation_stencil_core.f */
rtl/core/lgs_pkg.sv
rtl/core/lgs_sequencer.sv
rtl/core/lgs_stencil.sv
rtl/core/lgs_result_path.sv
rtl/core/life_generation_stencil_core.sv
verif/life_generation_stencil_core_tb.sv
